// File: design/q2e_pkg.sv
// Package for the quaternion to Euler angle pipeline.
// Holds the CORDIC angle table, the angle width and type, and the 90-degree constant.
// No dependencies.
package q2e_pkg;

  localparam int TAB_LEN = 24;
  localparam int ANG_W   = 32;  // degrees * 2^16, signed

  typedef logic signed [ANG_W-1:0] ang_t;

  function automatic ang_t atan_deg(input logic [4:0] idx);
    ang_t v;
    unique case (idx)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  localparam ang_t DEG90 = 32'sd5898240;

endpackage

// File: design/quaternion_to_euler_angles.sv
// Top level of the quaternion to Euler angle converter (ZYX order).
// Depends on q2e_pkg, q2e_cordic and q2e_isqrt.
//
//   channel | direction | tdata fields (low bit first)                | tuser
//   in_     | slave     | quat_real, quat_x, quat_y, quat_z (64 bits) | none
//   out_    | master    | pan_cdeg, tilt_cdeg, roll_cdeg (48 bits)    | tilt_clamped
//
// Unstalled, one word enters per cycle. Stages: two product stages, the tilt
// square root (33 stages), the CORDIC (CORDIC_STEPS + 1 stages, capped at 25)
// and two scaling stages. Pan and roll are delayed to meet the tilt path.
// The whole pipeline advances only when the output register is free or being
// taken, so a stall holds every word in place. Reset clears the valid bits.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_real, quat_x, quat_y, quat_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // pan_cdeg, tilt_cdeg, roll_cdeg, zero pad
  output logic        out_tuser   // tilt_clamped
);

  localparam int NS   = (CORDIC_STEPS < q2e_pkg::TAB_LEN) ? CORDIC_STEPS
                                                          : q2e_pkg::TAB_LEN;
  // Products of 16-bit inputs with doubling, wide enough to hold the unit value.
  localparam int PW   = (2 * FRAC_BITS + 2 > 36) ? 2 * FRAC_BITS + 2 : 36;
  localparam int SH   = 2 * FRAC_BITS - 30;
  localparam int LAT  = 2 + 33 + NS + 1 + 2;

  logic en;
  logic [LAT-1:0] vld_r;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end
  assign out_tvalid = vld_r[LAT-1];

  // Stage 1: the nine products.
  logic signed [15:0] qr, qx, qy, qz;
  assign qr = in_tdata[15:0];
  assign qx = in_tdata[31:16];
  assign qy = in_tdata[47:32];
  assign qz = in_tdata[63:48];

  logic signed [31:0] p_rx_r, p_yz_r, p_xx_r, p_yy_r, p_zz_r, p_rz_r, p_xy_r,
                      p_ry_r, p_zx_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_rx_r <= qr * qx;  p_yz_r <= qy * qz;  p_xx_r <= qx * qx;
      p_yy_r <= qy * qy;  p_zz_r <= qz * qz;  p_rz_r <= qr * qz;
      p_xy_r <= qx * qy;  p_ry_r <= qr * qy;  p_zx_r <= qz * qx;
    end
  end

  // Stage 2: the five atan2 and asin arguments.
  localparam logic signed [PW-1:0] ONE = PW'(64'sd1 <<< (2 * FRAC_BITS));
  logic signed [PW-1:0] sr_r, cr_r, sy_r, cy_r, sp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sr_r <= 2 * (PW'(p_rx_r) + PW'(p_yz_r));
      cr_r <= ONE - 2 * (PW'(p_xx_r) + PW'(p_yy_r));
      sy_r <= 2 * (PW'(p_rz_r) + PW'(p_xy_r));
      cy_r <= ONE - 2 * (PW'(p_yy_r) + PW'(p_zz_r));
      sp_r <= 2 * (PW'(p_ry_r) - PW'(p_zx_r));
    end
  end

  // Tilt argument at scale 2^30; the clamp decides before the square root.
  logic signed [63:0] s64, s30;
  logic               clamp_hi, clamp_lo;
  logic [30:0]        mag;
  logic [61:0]        mag2;
  assign s64      = 64'(sp_r);
  assign s30      = (SH >= 0) ? (s64 >>> ((SH >= 0) ? SH : 0))
                              : (s64 <<< ((SH < 0) ? -SH : 0));
  assign clamp_hi = sp_r >= ONE;
  assign clamp_lo = sp_r <= -ONE;
  assign mag      = s30[63] ? 31'(-s30) : 31'(s30);

  // Square stage: register magnitude, square next.
  logic [30:0]        mag_r;
  logic signed [31:0] s30_r;
  logic [1:0]         cl_r;
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag;
      s30_r <= 32'(s30);
      cl_r  <= {clamp_hi, clamp_lo};
    end
  end
  assign mag2 = 62'(mag_r) * 62'(mag_r);

  logic [60:0] rad;
  assign rad = 61'((62'd1 << 60) - mag2);

  logic [30:0] root;
  logic [33:0] side;
  q2e_isqrt #(.DW(34)) u_sqrt (
    .clk(clk), .en(en), .rad_in(rad), .side_in({cl_r, s30_r}),
    .root_out(root), .side_out(side)
  );

  // Pan and roll delay line to match the square root and squaring stage.
  localparam int DL = 33;
  logic signed [PW-1:0] d_sr_r [0:DL-1];
  logic signed [PW-1:0] d_cr_r [0:DL-1];
  logic signed [PW-1:0] d_sy_r [0:DL-1];
  logic signed [PW-1:0] d_cy_r [0:DL-1];
  always_ff @(posedge clk) begin
    if (en) begin
      d_sr_r[0] <= sr_r; d_cr_r[0] <= cr_r;
      d_sy_r[0] <= sy_r; d_cy_r[0] <= cy_r;
      for (int k = 1; k < DL; k++) begin
        d_sr_r[k] <= d_sr_r[k-1]; d_cr_r[k] <= d_cr_r[k-1];
        d_sy_r[k] <= d_sy_r[k-1]; d_cy_r[k] <= d_cy_r[k-1];
      end
    end
  end

  q2e_pkg::ang_t z_roll, z_pan, z_tilt;
  q2e_cordic #(.W(PW), .STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(en), .y_in(d_sr_r[DL-1]), .x_in(d_cr_r[DL-1]), .z_out(z_roll));
  q2e_cordic #(.W(PW), .STEPS(CORDIC_STEPS)) u_pan (
    .clk(clk), .en(en), .y_in(d_sy_r[DL-1]), .x_in(d_cy_r[DL-1]), .z_out(z_pan));
  q2e_cordic #(.W(33), .STEPS(CORDIC_STEPS)) u_tilt (
    .clk(clk), .en(en), .y_in(33'(signed'(side[31:0]))),
    .x_in({2'b00, root}), .z_out(z_tilt));

  // Clamp flags ride alongside the tilt CORDIC.
  logic [1:0] cd_r [0:NS];
  always_ff @(posedge clk) begin
    if (en) begin
      cd_r[0] <= side[33:32];
      for (int k = 1; k <= NS; k++) cd_r[k] <= cd_r[k-1];
    end
  end

  // Scale stage 1: magnitude times 100.
  logic [38:0] m_pan_r, m_tilt_r, m_roll_r;
  logic        n_pan_r, n_tilt_r, n_roll_r;
  logic [1:0]  cf_r;
  always_ff @(posedge clk) begin
    if (en) begin
      m_pan_r  <= 39'(z_pan[31]  ? 32'(-z_pan)  : 32'(z_pan))  * 39'd100;
      m_tilt_r <= 39'(z_tilt[31] ? 32'(-z_tilt) : 32'(z_tilt)) * 39'd100;
      m_roll_r <= 39'(z_roll[31] ? 32'(-z_roll) : 32'(z_roll)) * 39'd100;
      n_pan_r  <= z_pan[31];
      n_tilt_r <= z_tilt[31];
      n_roll_r <= z_roll[31];
      cf_r     <= cd_r[NS];
    end
  end

  // Scale stage 2: shift, saturate and sign.
  function automatic logic signed [15:0] fin(input logic [38:0] m, input logic neg,
                                             input logic [15:0] lim);
    logic [22:0] q;
    logic [15:0] s;
    q = m[38:16];
    s = (q > 23'(lim)) ? lim : q[15:0];
    return neg ? -signed'(s) : signed'(s);
  endfunction

  logic signed [15:0] pan_r, roll_r, tilt_r;
  logic               flag_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pan_r  <= fin(m_pan_r, n_pan_r, 16'd18000);
      roll_r <= fin(m_roll_r, n_roll_r, 16'd18000);
      flag_r <= |cf_r;
      if (cf_r[1])      tilt_r <= 16'sd9000;
      else if (cf_r[0]) tilt_r <= -16'sd9000;
      else              tilt_r <= fin(m_tilt_r, n_tilt_r, 16'd9000);
    end
  end

  assign out_tdata = {1'b0, roll_r, tilt_r[14:0], pan_r};
  assign out_tuser = flag_r;

endmodule

// File: design/q2e_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) in degrees * 2^16, one stage per step.
// Depends on q2e_pkg. Stalls with the shared enable en.
module q2e_cordic #(
  parameter int W     = 40,
  parameter int STEPS = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] y_in,
  input  logic signed [W-1:0] x_in,
  output q2e_pkg::ang_t       z_out
);

  localparam int N = (STEPS < q2e_pkg::TAB_LEN) ? STEPS : q2e_pkg::TAB_LEN;

  // One extra bit absorbs the CORDIC gain.
  logic signed [W:0] x_r [0:N];
  logic signed [W:0] y_r [0:N];
  q2e_pkg::ang_t     z_r [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in == '0 && y_in == '0) begin
        x_r[0] <= '0;
        y_r[0] <= '0;
        z_r[0] <= '0;
      end else if (x_in < 0) begin
        if (y_in >= 0) begin
          x_r[0] <= {y_in[W-1], y_in};
          y_r[0] <= -{x_in[W-1], x_in};
          z_r[0] <= q2e_pkg::DEG90;
        end else begin
          x_r[0] <= -{y_in[W-1], y_in};
          y_r[0] <= {x_in[W-1], x_in};
          z_r[0] <= -q2e_pkg::DEG90;
        end
      end else begin
        x_r[0] <= {x_in[W-1], x_in};
        y_r[0] <= {y_in[W-1], y_in};
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [W:0] dx, dy;
    // Zero inputs are detected and passed through unchanged, so z is held.
    logic              zero;
    assign dx   = x_r[i] >>> i;
    assign dy   = y_r[i] >>> i;
    assign zero = (x_r[i] == '0) && (y_r[i] == '0);
    always_ff @(posedge clk) begin
      if (en) begin
        if (zero) begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          z_r[i+1] <= z_r[i];
        end else if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          z_r[i+1] <= z_r[i] + q2e_pkg::atan_deg(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          z_r[i+1] <= z_r[i] - q2e_pkg::atan_deg(5'(i));
        end
      end
    end
  end

  assign z_out = z_r[N];

endmodule

// File: design/q2e_isqrt.sv
// Pipelined floor square root of a 61-bit radicand, one result bit per stage.
// Depends on nothing. Carries a side value of width DW alongside.
module q2e_isqrt #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [60:0]   rad_in,
  input  logic [DW-1:0] side_in,
  output logic [30:0]   root_out,
  output logic [DW-1:0] side_out
);

  localparam int NB = 31;

  logic [61:0]   rem_r  [0:NB];
  logic [30:0]   root_r [0:NB];
  logic [DW-1:0] side_r [0:NB];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {1'b0, rad_in};
      root_r[0] <= '0;
      side_r[0] <= side_in;
    end
  end

  // Stage k decides root bit NB-1-k against the remainder.
  for (genvar k = 0; k < NB; k++) begin : g_bit
    localparam int B = NB - 1 - k;
    logic [63:0] trial;
    assign trial = ({33'd0, root_r[k]} << (B + 1)) | (64'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1] <= side_r[k];
        if ({2'b00, rem_r[k]} >= trial) begin
          rem_r[k+1]  <= rem_r[k] - trial[61:0];
          root_r[k+1] <= root_r[k] | (31'd1 << B);
        end else begin
          rem_r[k+1]  <= rem_r[k];
          root_r[k+1] <= root_r[k];
        end
      end
    end
  end

  assign root_out = root_r[NB];
  assign side_out = side_r[NB];

endmodule

// File: design/q2e_checker.sv
// Port-level checker for the quaternion to Euler angle converter.
// Depends on quaternion_to_euler_angles; bound to it below.
module q2e_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed under stall");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output side");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[30:16] == 15'sd9000 || out_tdata[30:16] == -15'sd9000)
    else $error("clamp flag without full tilt");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[47])
    else $error("pad bit set");

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
);
